/* rtl/core/dpp_pkg.sv */
`default_nettype none

package dpp_pkg;

    // default image limits
    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned MAX_HEIGHT_DEF = 1024;

    // field widths
    localparam int SLOPE_W   = 20;
    localparam int OFFSET_W  = 32;
    localparam int DISP_W    = 32;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 2;

    // slope threshold -0.9 in Q3.16
    localparam logic signed [SLOPE_W-1:0] SLOPE_LIMIT = -20'sd58983;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_SCAN_BACKWARD = 2'd2
    } t_cfg_idx;

    // disparity plane d = a*x + b*y + c
    typedef struct packed {
        logic [OFFSET_W-1:0] c;
        logic [SLOPE_W-1:0]  b;
        logic [SLOPE_W-1:0]  a;
    } t_plane;

    // per-pixel scan position flags
    typedef struct packed {
        logic has_left;
        logic has_up;
        logic last;
    } t_scan_flags;

endpackage

`default_nettype wire

/* rtl/core/dpp_scan_ctrl.sv */
`default_nettype none

module dpp_scan_ctrl #(
    parameter int unsigned MAX_WIDTH  = dpp_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = dpp_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dpp_pkg::SIZE_W-1:0]    i_cfg_data,
    input  wire logic                          i_accept,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_col,
    output logic signed [$clog2(MAX_WIDTH):0]  o_x,
    output logic signed [$clog2(MAX_HEIGHT):0] o_y,
    output dpp_pkg::t_scan_flags               o_flags
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = $clog2(MAX_WIDTH + 1);
    localparam int SWH = $clog2(MAX_HEIGHT + 1);

    logic [dpp_pkg::SIZE_W-1:0] r_line_width;
    logic [dpp_pkg::SIZE_W-1:0] r_frame_height;
    logic                       r_scan_backward;
    logic [CW-1:0]              r_col;
    logic [RW-1:0]              r_row;

    logic [SWW-1:0] w_lim;
    logic [SWH-1:0] h_lim;
    logic           row_end;
    logic           col_end;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width    <= dpp_pkg::SIZE_W'(1024);
            r_frame_height  <= dpp_pkg::SIZE_W'(1024);
            r_scan_backward <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (dpp_pkg::t_cfg_idx'(i_cfg_index))
                dpp_pkg::CFG_LINE_WIDTH:    r_line_width    <= i_cfg_data;
                dpp_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                dpp_pkg::CFG_SCAN_BACKWARD: r_scan_backward <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sizes in use: zero reads as one, clipped at the maximum
    always_comb begin
        if (r_line_width == '0) begin
            w_lim = SWW'(1);
        end else if (32'(r_line_width) > 32'(MAX_WIDTH)) begin
            w_lim = SWW'(MAX_WIDTH);
        end else begin
            w_lim = SWW'(r_line_width);
        end
        if (r_frame_height == '0) begin
            h_lim = SWH'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_lim = SWH'(MAX_HEIGHT);
        end else begin
            h_lim = SWH'(r_frame_height);
        end
    end

    assign row_end = ((SWW+1)'(r_col) + (SWW+1)'(1)) >= (SWW+1)'(w_lim);
    assign col_end = ((SWH+1)'(r_row) + (SWH+1)'(1)) >= (SWH+1)'(h_lim);

    // scan position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= col_end ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // coordinates of the pixel being accepted
    always_comb begin
        if (r_scan_backward) begin
            o_x = $signed((CW+1)'(w_lim - SWW'(1))) - $signed({1'b0, r_col});
            o_y = $signed((RW+1)'(h_lim - SWH'(1))) - $signed({1'b0, r_row});
        end else begin
            o_x = $signed({1'b0, r_col});
            o_y = $signed({1'b0, r_row});
        end
    end

    assign o_col            = r_col;
    assign o_flags.has_left = (r_col != '0);
    assign o_flags.has_up   = (r_row != '0);
    assign o_flags.last     = row_end && col_end;

endmodule

`default_nettype wire

/* rtl/core/dpp_merge_stage.sv */
`default_nettype none

module dpp_merge_stage #(
    parameter int unsigned MAX_WIDTH  = dpp_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = dpp_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_load,
    input  wire logic                                i_move,
    input  wire dpp_pkg::t_plane                     i_plane,
    input  wire logic                                i_confident,
    input  wire logic                                i_on_edge,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]        i_col,
    input  wire logic signed [$clog2(MAX_WIDTH):0]   i_x,
    input  wire logic signed [$clog2(MAX_HEIGHT):0]  i_y,
    input  wire dpp_pkg::t_scan_flags                i_flags,
    output dpp_pkg::t_plane                          o_plane,
    output logic signed [$clog2(MAX_WIDTH):0]        o_x,
    output logic signed [$clog2(MAX_HEIGHT):0]       o_y,
    output logic                                     o_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = CW + 1;
    localparam int YW = $clog2(MAX_HEIGHT) + 1;
    localparam int SW = dpp_pkg::SLOPE_W;
    localparam int OW = dpp_pkg::OFFSET_W;

    typedef struct packed {
        logic            on_edge;
        dpp_pkg::t_plane plane;
    } t_line_entry;

    function automatic logic slope_ok(input logic [SW-1:0] a);
        return $signed(a) > dpp_pkg::SLOPE_LIMIT;
    endfunction

    // neighbor merge: skip, copy or floor average
    function automatic dpp_pkg::t_plane merge_plane(input dpp_pkg::t_plane own,
                                                    input dpp_pkg::t_plane nb,
                                                    input logic nb_edge);
        logic [SW:0]     sum_a;
        logic [SW:0]     sum_b;
        logic [OW:0]     sum_c;
        dpp_pkg::t_plane res;
        sum_a = {own.a[SW-1], own.a} + {nb.a[SW-1], nb.a};
        sum_b = {own.b[SW-1], own.b} + {nb.b[SW-1], nb.b};
        sum_c = {own.c[OW-1], own.c} + {nb.c[OW-1], nb.c};
        res   = own;
        if (!nb_edge && slope_ok(nb.a)) begin
            if (slope_ok(own.a)) begin
                res.a = sum_a[SW:1];
                res.b = sum_b[SW:1];
                res.c = sum_c[OW:1];
            end else begin
                res = nb;
            end
        end
        return res;
    endfunction

    // input stage
    dpp_pkg::t_plane      r_s1_plane;
    logic                 r_s1_conf;
    logic                 r_s1_edge;
    logic [CW-1:0]        r_s1_col;
    logic signed [XW-1:0] r_s1_x;
    logic signed [YW-1:0] r_s1_y;
    dpp_pkg::t_scan_flags r_s1_flags;

    // line buffer, previous row neighbor and its bypass
    t_line_entry r_line_mem [MAX_WIDTH];
    t_line_entry r_up_rd;
    t_line_entry r_byp_data;
    logic        r_up_byp;

    // left neighbor
    dpp_pkg::t_plane r_left_plane;
    logic            r_left_edge;

    // result stage
    dpp_pkg::t_plane      r_s2_plane;
    logic signed [XW-1:0] r_s2_x;
    logic signed [YW-1:0] r_s2_y;
    logic                 r_s2_last;

    t_line_entry     up;
    t_line_entry     wr_entry;
    dpp_pkg::t_plane p_left;
    dpp_pkg::t_plane p_new;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_plane <= i_plane;
            r_s1_conf  <= i_confident;
            r_s1_edge  <= i_on_edge;
            r_s1_col   <= i_col;
            r_s1_x     <= i_x;
            r_s1_y     <= i_y;
            r_s1_flags <= i_flags;
        end
    end

    // merge left neighbor first, then the one above
    always_comb begin
        up = r_up_byp ? r_byp_data : r_up_rd;
        if (!r_s1_conf && r_s1_flags.has_left) begin
            p_left = merge_plane(r_s1_plane, r_left_plane, r_left_edge);
        end else begin
            p_left = r_s1_plane;
        end
        if (!r_s1_conf && r_s1_flags.has_up) begin
            p_new = merge_plane(p_left, up.plane, up.on_edge);
        end else begin
            p_new = p_left;
        end
        wr_entry.on_edge = r_s1_edge;
        wr_entry.plane   = p_new;
    end

    // line buffer: write as a pixel leaves, read as the next one enters
    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_line_mem[r_s1_col] <= wr_entry;
        end
        if (i_load) begin
            r_up_rd <= r_line_mem[i_col];
        end
    end

    // same-column write in the same cycle (one-pixel rows)
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_up_byp   <= i_move && (r_s1_col == i_col);
            r_byp_data <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_plane <= '0;
            r_left_edge  <= 1'b0;
        end else if (i_move) begin
            r_left_plane <= p_new;
            r_left_edge  <= r_s1_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_s2_plane <= p_new;
            r_s2_x     <= r_s1_x;
            r_s2_y     <= r_s1_y;
            r_s2_last  <= r_s1_flags.last;
        end
    end

    assign o_plane = r_s2_plane;
    assign o_x     = r_s2_x;
    assign o_y     = r_s2_y;
    assign o_last  = r_s2_last;

endmodule

`default_nettype wire

/* rtl/core/dpp_disp_stage.sv */
`default_nettype none

module dpp_disp_stage #(
    parameter int unsigned MAX_WIDTH  = dpp_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = dpp_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_load_mul,
    input  wire logic                               i_load_out,
    input  wire dpp_pkg::t_plane                    i_plane,
    input  wire logic signed [$clog2(MAX_WIDTH):0]  i_x,
    input  wire logic signed [$clog2(MAX_HEIGHT):0] i_y,
    input  wire logic                               i_last,
    output dpp_pkg::t_plane                         o_plane,
    output logic [dpp_pkg::DISP_W-1:0]              o_disp,
    output logic                                    o_last
);

    localparam int XW   = $clog2(MAX_WIDTH) + 1;
    localparam int YW   = $clog2(MAX_HEIGHT) + 1;
    localparam int SW   = dpp_pkg::SLOPE_W;
    localparam int OW   = dpp_pkg::OFFSET_W;
    localparam int DW   = dpp_pkg::DISP_W;
    localparam int PXW  = SW + XW;
    localparam int PYW  = SW + YW;
    localparam int MW0  = (PXW > PYW) ? PXW : PYW;
    localparam int MW   = (MW0 > OW) ? MW0 : OW;
    localparam int SUMW = MW + 2;

    // product stage
    logic signed [PXW-1:0] r_px;
    logic signed [PYW-1:0] r_py;
    dpp_pkg::t_plane       r_m_plane;
    logic                  r_m_last;

    // output stage
    dpp_pkg::t_plane r_o_plane;
    logic [DW-1:0]   r_o_disp;
    logic            r_o_last;

    logic signed [SUMW-1:0] sum;
    logic [DW-1:0]          sat;
    logic                   in_range;

    always_ff @(posedge i_clk) begin
        if (i_load_mul) begin
            r_px      <= $signed(i_plane.a) * i_x;
            r_py      <= $signed(i_plane.b) * i_y;
            r_m_plane <= i_plane;
            r_m_last  <= i_last;
        end
    end

    // sum and clamp to 32 bits
    always_comb begin
        sum = SUMW'(r_px) + SUMW'(r_py) + SUMW'($signed(r_m_plane.c));
        in_range = (&sum[SUMW-1:DW-1]) || !(|sum[SUMW-1:DW-1]);
        if (in_range) begin
            sat = sum[DW-1:0];
        end else if (sum[SUMW-1]) begin
            sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_o_plane <= r_m_plane;
            r_o_disp  <= sat;
            r_o_last  <= r_m_last;
        end
    end

    assign o_plane = r_o_plane;
    assign o_disp  = r_o_disp;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

/* rtl/core/disparity_plane_propagation.sv */
`default_nettype none

// Spatial plane propagation over a pixel stream in scan order. Each item is one
// pixel: plane (a, b, c), a confident flag and an edge flag; each result is the
// updated plane, its disparity a*x+b*y+c (saturated) and tlast on the final pixel
// of the pass. The block takes one item per clock unless the output stalls; the
// left-neighbor recurrence closes inside the single merge stage; the previous
// row comes from a line buffer of MAX_WIDTH entries with one read and one write
// per pixel. Neither the line buffer nor reset needs a clearing pass. The user
// writes the size and direction registers via the cfg port only while no item is
// in flight; the block does not enforce it. Scan position is kept across writes.
module disparity_plane_propagation #(
    parameter int unsigned MAX_WIDTH  = dpp_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = dpp_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write port
    input  wire logic                          i_cfg_we,
    input  wire logic [dpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dpp_pkg::SIZE_W-1:0]    i_cfg_data,
    // input pixels
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [71:0]                   i_s_axis_tdata,  // in_slope_x, in_slope_y, in_offset
    input  wire logic [1:0]                    i_s_axis_tuser,  // confident, on_edge
    // results
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [103:0]                       o_m_axis_tdata,  // out_slope_x, out_slope_y,
                                                                // out_offset, disparity
    output logic                               o_m_axis_tlast   // frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = CW + 1;
    localparam int YW = $clog2(MAX_HEIGHT) + 1;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic accept;
    logic load2;
    logic load3;
    logic load4;
    logic out_fire;

    logic [CW-1:0]        col;
    logic signed [XW-1:0] x;
    logic signed [YW-1:0] y;
    dpp_pkg::t_scan_flags flags;
    dpp_pkg::t_plane      in_plane;

    dpp_pkg::t_plane      s2_plane;
    logic signed [XW-1:0] s2_x;
    logic signed [YW-1:0] s2_y;
    logic                 s2_last;

    dpp_pkg::t_plane            out_plane;
    logic [dpp_pkg::DISP_W-1:0] out_disp;

    // stage handshake: a stage loads when empty or draining
    assign out_fire = r_v4 && i_m_axis_tready;
    assign rdy4     = !r_v4 || i_m_axis_tready;
    assign rdy3     = !r_v3 || rdy4;
    assign rdy2     = !r_v2 || rdy3;
    assign rdy1     = !r_v1 || rdy2;
    assign accept   = i_s_axis_tvalid && rdy1;
    assign load2    = r_v1 && rdy2;
    assign load3    = r_v2 && rdy3;
    assign load4    = r_v3 && rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= accept || (r_v1 && !load2);
            r_v2 <= load2  || (r_v2 && !load3);
            r_v3 <= load3  || (r_v3 && !load4);
            r_v4 <= load4  || (r_v4 && !out_fire);
        end
    end

    // unpack item
    assign in_plane.a = i_s_axis_tdata[19:0];
    assign in_plane.b = i_s_axis_tdata[39:20];
    assign in_plane.c = i_s_axis_tdata[71:40];

    dpp_scan_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_col       (col),
        .o_x         (x),
        .o_y         (y),
        .o_flags     (flags)
    );

    dpp_merge_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_move      (load2),
        .i_plane     (in_plane),
        .i_confident (i_s_axis_tuser[0]),
        .i_on_edge   (i_s_axis_tuser[1]),
        .i_col       (col),
        .i_x         (x),
        .i_y         (y),
        .i_flags     (flags),
        .o_plane     (s2_plane),
        .o_x         (s2_x),
        .o_y         (s2_y),
        .o_last      (s2_last)
    );

    dpp_disp_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_disp (
        .i_clk      (i_clk),
        .i_load_mul (load3),
        .i_load_out (load4),
        .i_plane    (s2_plane),
        .i_x        (s2_x),
        .i_y        (s2_y),
        .i_last     (s2_last),
        .o_plane    (out_plane),
        .o_disp     (out_disp),
        .o_last     (o_m_axis_tlast)
    );

    assign o_s_axis_tready = rdy1;
    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {out_disp, out_plane.c, out_plane.b, out_plane.a};

endmodule

`default_nettype wire
